[hw/rtl/cac_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cac_pkg
// Shared types and constants for the classification accuracy counter.
// ----------------------------------------------------------------------------
package cac_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int DATA_WIDTH = 16;
  localparam int CFG_W      = 11;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int CNT_W      = 16;
  localparam int FRAC_W     = CNT_W + 1;
  localparam int STEP_W     = $clog2(FRAC_W + 1);
  localparam int STATUS_W   = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // 0.5 in Q4.12
  localparam logic signed [DATA_WIDTH-1:0] HALF_Q = DATA_WIDTH'(1 << (DATA_WIDTH - 5));

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_PARTIAL  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

endpackage

`default_nettype wire

[hw/rtl/cac_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cac_in_if
// Element-pair stream channel: one label/prediction pair per transfer.
// ----------------------------------------------------------------------------
interface cac_in_if;
  import cac_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] true_value;
  logic signed [DATA_WIDTH-1:0] pred_value;
  logic                         last_of_batch;

  modport source (output valid, output true_value, output pred_value,
                  output last_of_batch, input ready);
  modport sink   (input valid, input true_value, input pred_value,
                  input last_of_batch, output ready);
endinterface

`default_nettype wire

[hw/rtl/cac_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cac_out_if
// Batch result channel: counts, accuracy ratio and status per transfer.
// ----------------------------------------------------------------------------
interface cac_out_if;
  import cac_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CNT_W-1:0]      correct_count;
  logic [CNT_W-1:0]      row_count;
  logic [FRAC_W-1:0]     accuracy_frac;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, output correct_count, output row_count,
                  output accuracy_frac, output status, input ready);
  modport sink   (input valid, input correct_count, input row_count,
                  input accuracy_frac, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/classification_accuracy_counter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// classification_accuracy_counter
// Top-1 accuracy over a batch of label/prediction rows with a Q1.16 ratio.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while in_i.ready is high; running argmax
// and counts update in the transfer cycle. The last element of a batch closes
// it; the FSM then runs S_FIN, S_DIV (divider, on success only) and S_DONE,
// and in_i.ready stays low until the result is loaded.
// Reset is asynchronous, active low: num_cols = 1, all batch state cleared.
// ----------------------------------------------------------------------------
module classification_accuracy_counter import cac_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  cac_in_if.sink                in_i,
  cac_out_if.source             out_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FIN  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]             num_cols_q;
  logic [COL_W-1:0]             col_q, col_d;
  logic signed [DATA_WIDTH-1:0] bt_val_q, bt_val_d, bp_val_q, bp_val_d;
  logic [COL_W-1:0]             bt_idx_q, bt_idx_d, bp_idx_q, bp_idx_d;
  logic [CNT_W-1:0]             corr_q, corr_d, rows_q, rows_d;
  logic                         ovf_q, ovf_d;

  logic [CNT_W-1:0]             res_corr_q, res_corr_d, res_rows_q, res_rows_d;
  status_e                      res_status_q, res_status_d;

  logic                         out_valid_q, out_valid_d;
  logic [CNT_W-1:0]             out_corr_q, out_corr_d, out_rows_q, out_rows_d;
  logic [FRAC_W-1:0]            out_frac_q, out_frac_d;
  status_e                      out_status_q, out_status_d;

  logic [CFG_W-1:0]             cols_eff;
  logic                         thresh_mode, row_end, match, in_xfer, out_free;
  logic                         div_start, div_done;
  logic [FRAC_W-1:0]            div_quot;
  status_e                      fin_status;

  always_comb begin
    priority if (num_cols_q == '0) cols_eff = CFG_W'(1);
    else if (num_cols_q > CFG_W'(MAX_COLS)) cols_eff = CFG_W'(MAX_COLS);
    else cols_eff = num_cols_q;
  end

  assign thresh_mode = cols_eff == CFG_W'(1);
  assign in_i.ready  = state_q == S_IDLE;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  always_comb begin
    priority if (col_q != '0 || rows_q == '0) fin_status = ST_PARTIAL;
    else if (ovf_q) fin_status = ST_OVERFLOW;
    else fin_status = ST_OK;
  end

  assign div_start = (state_q == S_FIN) && (fin_status == ST_OK);

  cac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (corr_q),
    .den_i   (rows_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    bt_val_d     = bt_val_q;
    bt_idx_d     = bt_idx_q;
    bp_val_d     = bp_val_q;
    bp_idx_d     = bp_idx_q;
    corr_d       = corr_q;
    rows_d       = rows_q;
    ovf_d        = ovf_q;
    res_corr_d   = res_corr_q;
    res_rows_d   = res_rows_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_corr_d   = out_corr_q;
    out_rows_d   = out_rows_q;
    out_frac_d   = out_frac_q;
    out_status_d = out_status_q;
    row_end      = 1'b0;
    match        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (thresh_mode) begin
            col_d   = '0;
            row_end = 1'b1;
            match   = (in_i.true_value >= HALF_Q) == (in_i.pred_value >= HALF_Q);
          end else begin
            if (col_q == '0) begin
              bt_val_d = in_i.true_value;
              bt_idx_d = '0;
              bp_val_d = in_i.pred_value;
              bp_idx_d = '0;
            end else begin
              if (in_i.true_value > bt_val_q) begin
                bt_val_d = in_i.true_value;
                bt_idx_d = col_q;
              end
              if (in_i.pred_value > bp_val_q) begin
                bp_val_d = in_i.pred_value;
                bp_idx_d = col_q;
              end
            end
            row_end = (CFG_W'(col_q) + CFG_W'(1)) >= cols_eff;
            match   = bt_idx_d == bp_idx_d;
            col_d   = row_end ? '0 : col_q + COL_W'(1);
          end
          if (row_end) begin
            if (rows_q == COUNT_MAX) ovf_d = 1'b1;
            else rows_d = rows_q + CNT_W'(1);
            if (match && corr_q != COUNT_MAX) corr_d = corr_q + CNT_W'(1);
          end
          if (in_i.last_of_batch) state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_corr_d   = corr_q;
        res_rows_d   = rows_q;
        res_status_d = fin_status;
        col_d        = '0;
        bt_val_d     = '0;
        bt_idx_d     = '0;
        bp_val_d     = '0;
        bp_idx_d     = '0;
        corr_d       = '0;
        rows_d       = '0;
        ovf_d        = 1'b0;
        state_d      = (fin_status == ST_OK) ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_corr_d   = res_corr_q;
          out_rows_d   = res_rows_q;
          out_frac_d   = (res_status_q == ST_OK) ? div_quot : '0;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_cols_q  <= CFG_W'(1);
      col_q       <= '0;
      bt_val_q    <= '0;
      bt_idx_q    <= '0;
      bp_val_q    <= '0;
      bp_idx_q    <= '0;
      corr_q      <= '0;
      rows_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) num_cols_q <= cfg_wdata_i;
      col_q       <= col_d;
      bt_val_q    <= bt_val_d;
      bt_idx_q    <= bt_idx_d;
      bp_val_q    <= bp_val_d;
      bp_idx_q    <= bp_idx_d;
      corr_q      <= corr_d;
      rows_q      <= rows_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_corr_q   <= res_corr_d;
    res_rows_q   <= res_rows_d;
    res_status_q <= res_status_d;
    out_corr_q   <= out_corr_d;
    out_rows_q   <= out_rows_d;
    out_frac_q   <= out_frac_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.correct_count = out_corr_q;
  assign out_o.row_count     = out_rows_q;
  assign out_o.accuracy_frac = out_frac_q;
  assign out_o.status        = out_status_q;

endmodule

`default_nettype wire

[hw/rtl/cac_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cac_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den).
// Requires num <= den; result holds until the next start.
// ----------------------------------------------------------------------------
module cac_div import cac_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CNT_W-1:0]  num_i,
  input  wire logic [CNT_W-1:0]  den_i,
  output logic                   done_o,
  output logic [FRAC_W-1:0]      quot_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [FRAC_W-1:0] quot_q, quot_d;
  logic              ge;
  logic [CNT_W:0]    rem_sub;

  assign ge      = rem_q >= {1'b0, den_q};
  assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(FRAC_W);
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = {rem_sub[CNT_W-1:0], 1'b0};
      quot_d = {quot_q[FRAC_W-2:0], ge};
      cnt_d  = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the classification accuracy counter. A scoreboard
// class predicts each batch result from the accepted element transfers and
// checks the result stream in order. Directed batches cover the threshold
// edge, argmax ties, partial and empty batches, column clamping and a column
// change in the middle of a batch. Random batches then run under several
// sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cac_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_PAIRS   = 250;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [CNT_W-1:0]    correct_count;
    logic [CNT_W-1:0]    row_count;
    logic [FRAC_W-1:0]   accuracy_frac;
    logic [STATUS_W-1:0] status;
  } batch_result_t;

  class accuracy_board;
    logic [CFG_W-1:0] cols_reg;
    int unsigned      col_pos;
    int               best_true;
    int               best_pred;
    int unsigned      best_true_col;
    int unsigned      best_pred_col;
    int unsigned      hits;
    int unsigned      rows;
    bit               row_overflow;
    batch_result_t    expected_q[$];
    int unsigned      fails;
    int unsigned      results_seen;

    function new();
      cols_reg     = 1;
      fails        = 0;
      results_seen = 0;
      clear_batch();
    endfunction

    function void clear_batch();
      col_pos       = 0;
      best_true     = 0;
      best_pred     = 0;
      best_true_col = 0;
      best_pred_col = 0;
      hits          = 0;
      rows          = 0;
      row_overflow  = 0;
    endfunction

    function int unsigned width_used();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return cols_reg;
    endfunction

    function void close_row(bit match);
      if (rows >= COUNT_MAX) begin
        row_overflow = 1;
        rows         = COUNT_MAX;
      end else begin
        rows++;
      end
      if (match && hits < COUNT_MAX) hits++;
    endfunction

    function void note_pair(logic signed [DATA_WIDTH-1:0] tv,
                            logic signed [DATA_WIDTH-1:0] pv, bit last);
      int            t;
      int            p;
      int unsigned   w;
      longint unsigned q;
      batch_result_t r;
      t = tv;
      p = pv;
      w = width_used();
      if (w == 1) begin
        col_pos = 0;
        close_row((t >= int'(HALF_Q)) == (p >= int'(HALF_Q)));
      end else begin
        if (col_pos == 0) begin
          best_true     = t;
          best_true_col = 0;
          best_pred     = p;
          best_pred_col = 0;
        end else begin
          if (t > best_true) begin
            best_true     = t;
            best_true_col = col_pos;
          end
          if (p > best_pred) begin
            best_pred     = p;
            best_pred_col = col_pos;
          end
        end
        if (col_pos + 1 >= w) begin
          col_pos = 0;
          close_row(best_true_col == best_pred_col);
        end else begin
          col_pos++;
        end
      end
      if (!last) return;
      r.correct_count = CNT_W'(hits);
      r.row_count     = CNT_W'(rows);
      r.accuracy_frac = '0;
      if (col_pos != 0 || rows == 0) r.status = ST_PARTIAL;
      else if (row_overflow) r.status = ST_OVERFLOW;
      else r.status = ST_OK;
      if (r.status == ST_OK) begin
        q = (longint'(hits) << 16) / rows;
        r.accuracy_frac = FRAC_W'(q);
      end
      expected_q.push_back(r);
      clear_batch();
    endfunction

    function void check_result(batch_result_t got);
      batch_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: correct %0d rows %0d frac %0d status %0d",
                   got.correct_count, got.row_count, got.accuracy_frac, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10) begin
          $display("mismatch at %0t: exp correct %0d rows %0d frac %0d status %0d",
                   $realtime, want.correct_count, want.row_count,
                   want.accuracy_frac, want.status);
          $display("  got correct %0d rows %0d frac %0d status %0d",
                   got.correct_count, got.row_count, got.accuracy_frac, got.status);
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  cac_in_if  in_ch ();
  cac_out_if out_ch ();

  classification_accuracy_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  accuracy_board board = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_req;
  int unsigned sent_pairs;
  int unsigned cfg_writes;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // result side: stall pattern plus requested hold-off
  initial begin : receiver
    int unsigned hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    batch_result_t got;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.correct_count = out_ch.correct_count;
      got.row_count     = out_ch.row_count;
      got.accuracy_frac = out_ch.accuracy_frac;
      got.status        = out_ch.status;
      board.check_result(got);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_pair(logic signed [DATA_WIDTH-1:0] tv,
                           logic signed [DATA_WIDTH-1:0] pv, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.true_value    <= tv;
    in_ch.pred_value    <= pv;
    in_ch.last_of_batch <= last;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    board.note_pair(tv, pv, last);
    sent_pairs++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cols(logic [CFG_W-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i       <= 1'b0;
    board.cols_reg = v;
    cfg_writes++;
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_value(int unsigned mode);
    case (mode)
      0: return DATA_WIDTH'($urandom);
      1: return DATA_WIDTH'(int'($urandom_range(8)) - 4);
      2: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return HALF_Q;
          default: return HALF_Q - 16'sd1;
        endcase
      end
      default: return HALF_Q + DATA_WIDTH'(int'($urandom_range(4)) - 2);
    endcase
  endfunction

  task automatic send_rows(int unsigned nrows, int unsigned extra, bit close);
    int unsigned w;
    int unsigned total;
    int unsigned mode;
    bit          copy;
    logic signed [DATA_WIDTH-1:0] tv;
    w     = board.width_used();
    total = nrows * w + extra;
    mode  = 0;
    copy  = 0;
    for (int unsigned i = 0; i < total; i++) begin
      if (i % w == 0) begin
        mode = $urandom_range(3);
        copy = ($urandom_range(99) < 45);
      end
      tv = pick_value(mode);
      send_pair(tv, copy ? tv : pick_value(mode), close && (i == total - 1));
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_cols();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 25) return 1;
    if (r < 80) return CFG_W'($urandom_range(2, 8));
    if (r < 95) return CFG_W'($urandom_range(9, 40));
    return CFG_W'($urandom_range(41, 100));
  endfunction

  task automatic run_segment();
    int unsigned nb;
    int unsigned w;
    int unsigned nrows;
    int unsigned extra;
    nb = $urandom_range(1, 4);
    for (int unsigned b = 0; b < nb; b++) begin
      w     = board.width_used();
      nrows = (w == 1) ? $urandom_range(1, 12) :
              (w > 40) ? $urandom_range(1, 2) : $urandom_range(1, 6);
      extra = 0;
      if (w > 1 && $urandom_range(99) < 15) begin
        extra = $urandom_range(1, w - 1);
        nrows = $urandom_range(nrows);
      end
      send_rows(nrows, extra, 1'b1);
    end
    // leave a row open across the next register write now and then
    w = board.width_used();
    if (w > 1 && $urandom_range(99) < 20) send_rows(0, $urandom_range(1, w - 1), 1'b0);
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    in_ch.valid         = 1'b0;
    in_ch.true_value    = '0;
    in_ch.pred_value    = '0;
    in_ch.last_of_batch = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_req            = 0;
    sent_pairs          = 0;
    cfg_writes          = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // threshold mode from reset, values around 0.5
    send_pair(HALF_Q, HALF_Q, 1'b0);
    send_pair(HALF_Q - 16'sd1, HALF_Q, 1'b0);
    send_pair(16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'sh8000, HALF_Q - 16'sd1, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);

    // zero columns acts as one
    write_cols(0);
    send_pair(0, 0, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 1'b1);

    // argmax: ties, max in last column, mismatch
    write_cols(3);
    send_pair(5, 5, 1'b0);
    send_pair(5, 5, 1'b0);
    send_pair(5, 5, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b0);
    send_pair(1, 1, 1'b0);
    send_pair(9, 2, 1'b0);
    send_pair(3, 9, 1'b1);

    // partial last row, then a batch with no complete row
    send_pair(0, 0, 1'b0);
    send_pair(0, 0, 1'b0);
    send_pair(0, 0, 1'b0);
    send_pair(1, 1, 1'b1);
    send_pair(7, 7, 1'b1);

    // narrower row while the index is already past the new last column
    write_cols(4);
    send_pair(1, 3, 1'b0);
    send_pair(2, 2, 1'b0);
    send_pair(3, 1, 1'b0);
    write_cols(2);
    send_pair(9, 0, 1'b0);
    send_pair(0, 0, 1'b0);
    send_pair(0, 0, 1'b1);

    // column clamping
    write_cols(2047);
    send_pair(1, 1, 1'b0);
    send_pair(2, 2, 1'b1);
    write_cols(1025);
    send_pair(3, 3, 1'b1);
    write_cols(1024);
    send_rows(0, 5, 1'b1);

    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      phase_start = sent_pairs;
      if (phase == 0) begin
        // long receiver hold-off while short batches keep coming
        write_cols(1);
        hold_req = HOLD_CYCLES;
        repeat (12) send_rows(2, 0, 1'b1);
        wait_drained();
      end
      while (sent_pairs - phase_start < PHASE_PAIRS) begin
        write_cols(pick_cols());
        run_segment();
      end
    end

    wait_drained();
    $display("ran %0d element transfers, %0d batch results, %0d column settings",
             sent_pairs, board.results_seen, cfg_writes);
    $display("%0d result mismatches", board.fails);
    if (board.fails == 0 && board.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
